// ===== sv/qscd_pkg.sv =====
`default_nettype none
package qscd_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_MODE   = 3'd0,
      CSR_STEP   = 3'd1,
      CSR_PGAIN  = 3'd2,
      CSR_IGAIN  = 3'd3,
      CSR_FLIMIT = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_I,
      ST_SQ_Q,
      ST_SQRT,
      ST_MUL_IC,
      ST_MUL_QS,
      ST_MUL_IS,
      ST_MUL_QC,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ERR,
      ST_MUL_KI,
      ST_INTEG,
      ST_MUL_KP,
      ST_PHASE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_LOAD,
      MAC_ADD,
      MAC_SUB
   } mac_op_type;

   typedef struct packed {
      logic load_sqrt;
      logic step_sqrt;
      logic load_div;
      logic step_div;
   } iter_ctl_type;

   localparam int SQRT_STEPS = 24;
   localparam int DIV_STEPS  = 15;

   // odd Taylor coefficients of sin, Q30
   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint SIN_A1  = 64'sd1686629713;
   localparam longint SIN_A3  = 64'sd693598668;
   localparam longint SIN_A5  = 64'sd85569306;
   localparam longint SIN_A7  = 64'sd5026993;
   localparam longint SIN_A9  = 64'sd172272;
   localparam longint SIN_A11 = 64'sd3864;

   // quarter wave, 257 points, magnitude in Q15
   typedef logic [14:0] qsine_tab_type [0:256];

   function automatic qsine_tab_type qsine_build();
      qsine_tab_type tab;
      longint t, t2, poly, s, v;
      for (int j = 0; j <= 256; j++) begin
         t    = longint'(j) <<< 22;
         t2   = (t * t) / Q30_ONE;
         poly = -SIN_A11;
         poly = SIN_A9 + (poly * t2) / Q30_ONE;
         poly = -SIN_A7 + (poly * t2) / Q30_ONE;
         poly = SIN_A5 + (poly * t2) / Q30_ONE;
         poly = -SIN_A3 + (poly * t2) / Q30_ONE;
         poly = SIN_A1 + (poly * t2) / Q30_ONE;
         s    = (poly * t) / Q30_ONE;
         v    = (s > 0) ? ((s + 64'sd16384) >>> 15) : 64'sd0;
         if (v > 64'sd32767) begin
            v = 64'sd32767;
         end
         tab[j] = v[14:0];
      end
      return tab;
   endfunction

   localparam qsine_tab_type QSINE_TAB = qsine_build();

   // Q1.15 sine of a 10-bit phase index
   function automatic logic signed [15:0] sine_lookup(input logic [9:0] idx);
      logic [8:0]  j;
      logic [14:0] mag;
      j   = idx[8] ? (9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
      mag = QSINE_TAB[j];
      return idx[9] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
   endfunction

endpackage
`default_nettype wire

// ===== sv/am_quasi_sync_carrier_detector_top.sv =====
`default_nettype none
// Channel   | Dir | Handshake          | Payload
// req_      | in  | req_tvalid/tready  | tdata[15:0] in_phase, [31:16] quadrature
// rsp_      | out | rsp_tvalid/tready  | tdata[17:0] video_sample, [23:18] zero
// csr_      | in  | csr_wen            | csr_addr index, csr_wdata value
//
// One item at a time. Each item runs the 24-step square root and, in quasi-sync
// mode, the 15-step divide on the shared iterative unit, plus passes through
// the one shared multiply-accumulate (eight in quasi-sync mode, two in envelope).
// req_tready is high only while the sequencer is idle. A finished result sits in
// the output register; a stalled rsp_ side holds the next result in the
// sequencer until the register frees. Reset (synchronous) loads register
// defaults and clears the NCO phase and loop integrator.
module am_quasi_sync_carrier_detector_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] in_phase, [31:16] quadrature
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // [17:0] video_sample, [23:18] zero
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [45:0] csr_wdata
);
   import qscd_pkg::*;

   // config
   logic        mode_ff;
   logic [31:0] step_ff;
   logic [23:0] pgain_ff;
   logic [23:0] igain_ff;
   logic [45:0] flimit_ff;

   // loop state
   logic [31:0]        phase_ff, phase_in;
   logic signed [47:0] integ_ff, integ_in;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff;

   logic signed [15:0] i_ff, q_ff, s_ff, c_ff, e_ff, e_in;
   logic signed [40:0] acc_ff, acc_in, prod;
   logic signed [24:0] mul_a;
   logic signed [15:0] mul_b;
   mac_op_type         mac_op;
   iter_ctl_type       iter_ctl;

   logic [17:0] vid_ff, vid_in;
   logic        rsp_valid_ff;
   logic [17:0] rsp_video_ff;

   // sequencer strobes
   logic ld_in, ld_lut, ld_vid, ld_e, ld_integ, ld_phase, ld_rsp;

   logic [23:0] root;
   logic [14:0] quo;
   logic        sat;
   logic [31:0] yi_abs;

   qscd_iter_unit u_iter (
      .clock    (clock),
      .ctl      (iter_ctl),
      .radicand (acc_in[31:0]),
      .dividend (yi_abs),
      .root     (root),
      .quo      (quo),
      .sat      (sat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_SQ_I;
         ST_SQ_I:     state_in = ST_SQ_Q;
         ST_SQ_Q:     state_in = ST_SQRT;
         ST_SQRT: begin
            if (cnt_ff == 5'(SQRT_STEPS - 1)) state_in = mode_ff ? ST_MUL_IC : ST_DONE;
         end
         ST_MUL_IC:   state_in = ST_MUL_QS;
         ST_MUL_QS:   state_in = ST_MUL_IS;
         ST_MUL_IS:   state_in = ST_MUL_QC;
         ST_MUL_QC:   state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = ST_ERR;
         end
         ST_ERR:      state_in = ST_MUL_KI;
         ST_MUL_KI:   state_in = ST_INTEG;
         ST_INTEG:    state_in = ST_MUL_KP;
         ST_MUL_KP:   state_in = ST_PHASE;
         ST_PHASE:    state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mac_op     = MAC_HOLD;
      mul_a      = 25'(i_ff);
      mul_b      = i_ff;
      iter_ctl   = '0;
      ld_in      = 1'b0;
      ld_lut     = 1'b0;
      ld_vid     = 1'b0;
      ld_e       = 1'b0;
      ld_integ   = 1'b0;
      ld_phase   = 1'b0;
      ld_rsp     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ld_in      = req_tvalid;
         end
         ST_SQ_I: begin
            mac_op = MAC_LOAD;
            ld_lut = 1'b1;
         end
         ST_SQ_Q: begin
            mul_a              = 25'(q_ff);
            mul_b              = q_ff;
            mac_op             = MAC_ADD;
            iter_ctl.load_sqrt = 1'b1;
         end
         ST_SQRT:     iter_ctl.step_sqrt = 1'b1;
         ST_MUL_IC: begin
            mul_b  = c_ff;
            mac_op = MAC_LOAD;
         end
         ST_MUL_QS: begin
            mul_a  = 25'(q_ff);
            mul_b  = s_ff;
            mac_op = MAC_SUB;
         end
         ST_MUL_IS: begin
            mul_b  = s_ff;
            mac_op = MAC_LOAD;
            ld_vid = 1'b1;          // acc holds the real part here
         end
         ST_MUL_QC: begin
            mul_a  = 25'(q_ff);
            mul_b  = c_ff;
            mac_op = MAC_ADD;
         end
         ST_DIV_LOAD: iter_ctl.load_div = 1'b1;
         ST_DIV:      iter_ctl.step_div = 1'b1;
         ST_ERR:      ld_e = 1'b1;
         ST_MUL_KI: begin
            mul_a  = signed'({1'b0, igain_ff});
            mul_b  = e_ff;
            mac_op = MAC_LOAD;
         end
         ST_INTEG:    ld_integ = 1'b1;
         ST_MUL_KP: begin
            mul_a  = signed'({1'b0, pgain_ff});
            mul_b  = e_ff;
            mac_op = MAC_LOAD;
         end
         ST_PHASE:    ld_phase = 1'b1;
         ST_DONE:     ld_rsp = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // shared multiply-accumulate
   assign prod = mul_a * mul_b;

   always_comb begin
      case (mac_op)
         MAC_LOAD: acc_in = prod;
         MAC_ADD:  acc_in = acc_ff + prod;
         MAC_SUB:  acc_in = acc_ff - prod;
         default:  acc_in = acc_ff;
      endcase
   end

   // |Im| for the divider; below 2^31 by range
   always_comb begin
      logic signed [40:0] neg;
      neg    = -acc_ff;
      yi_abs = acc_ff[40] ? neg[31:0] : acc_ff[31:0];
   end

   // rounded real part, doubled, saturated
   always_comb begin
      logic signed [40:0] vt;
      vt = (acc_ff + 41'sd16384) >>> 15;
      if (vt > 41'sd65535) begin
         vid_in = 18'h1FFFF;
      end else if (vt < -41'sd65536) begin
         vid_in = 18'h20000;
      end else begin
         vid_in = {vt[16:0], 1'b0};
      end
   end

   // phase error, Q1.15; zero magnitude gives zero error
   always_comb begin
      logic neg;
      neg = acc_ff[40];
      if (root == 24'd0) begin
         e_in = '0;
      end else if (sat) begin
         e_in = neg ? 16'sh8000 : 16'sh7FFF;
      end else begin
         e_in = neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
      end
   end

   // clamped integrator
   always_comb begin
      logic signed [47:0] sum, lim;
      sum = integ_ff + 48'(acc_ff >>> 15);
      lim = signed'({2'b00, flimit_ff});
      if (sum > lim) begin
         integ_in = lim;
      end else if (sum < -lim) begin
         integ_in = -lim;
      end else begin
         integ_in = sum;
      end
   end

   // NCO retune: phase -= step + prop term + integ/2^16
   always_comb begin
      logic signed [40:0] pterm;
      pterm    = acc_ff >>> 15;
      phase_in = phase_ff - step_ff - pterm[31:0] - integ_ff[47:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= 1'b1;
         step_ff      <= 32'd0;
         pgain_ff     <= 24'd683565;
         igain_ff     <= 24'd448000;
         flimit_ff    <= 46'd1759218604442;
         phase_ff     <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_SQRT || state_ff == ST_DIV) begin
            cnt_ff <= (state_in == state_ff) ? cnt_ff + 5'd1 : 5'd0;
         end else begin
            cnt_ff <= '0;
         end
         if (ld_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wen) begin
            case (csr_addr)
               CSR_MODE:   mode_ff   <= csr_wdata[0];
               CSR_STEP:   step_ff   <= csr_wdata[31:0];
               CSR_PGAIN:  pgain_ff  <= csr_wdata[23:0];
               CSR_IGAIN:  igain_ff  <= csr_wdata[23:0];
               CSR_FLIMIT: flimit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (ld_integ) integ_ff <= integ_in;
         if (ld_phase) phase_ff <= phase_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ld_in) begin
         i_ff <= signed'(req_tdata[15:0]);
         q_ff <= signed'(req_tdata[31:16]);
      end
      if (ld_lut) begin
         s_ff <= sine_lookup(phase_ff[31:22]);
         c_ff <= sine_lookup(phase_ff[31:22] + 10'd256);
      end
      if (ld_vid) vid_ff <= vid_in;
      if (ld_e)   e_ff   <= e_in;
      if (ld_rsp) rsp_video_ff <= mode_ff ? vid_ff : {1'b0, root[23:8], 1'b0};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_video_ff};

endmodule
`default_nettype wire

// ===== sv/qscd_iter_unit.sv =====
`default_nettype none
// Shared bit-serial unit: square root (2 radicand bits per step) and
// restoring division (1 quotient bit per step).
module qscd_iter_unit (
   input  wire logic                  clock,
   input  wire qscd_pkg::iter_ctl_type ctl,
   input  wire logic [31:0]           radicand,
   input  wire logic [31:0]           dividend,
   output logic      [23:0]           root,
   output logic      [14:0]           quo,
   output logic                       sat
);
   import qscd_pkg::*;

   logic [25:0] rem_ff, rem_in;
   logic [47:0] shift_ff, shift_in;
   logic [23:0] root_ff, root_in;
   logic [14:0] quo_ff, quo_in;
   logic        sat_ff, sat_in;

   logic [26:0] sq_cat, sq_sub;
   logic [25:0] dv_cat;

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      root_in  = root_ff;
      quo_in   = quo_ff;
      sat_in   = sat_ff;
      sq_cat   = {rem_ff[24:0], shift_ff[47:46]};
      sq_sub   = {1'b0, root_ff, 2'b01};
      dv_cat   = {rem_ff[24:0], shift_ff[47]};
      if (ctl.load_sqrt) begin
         shift_in = {radicand, 16'd0};
         rem_in   = '0;
         root_in  = '0;
      end else if (ctl.step_sqrt) begin
         shift_in = {shift_ff[45:0], 2'b00};
         if (sq_cat >= sq_sub) begin
            rem_in  = 26'(sq_cat - sq_sub);
            root_in = {root_ff[22:0], 1'b1};
         end else begin
            rem_in  = sq_cat[25:0];
            root_in = {root_ff[22:0], 1'b0};
         end
      end else if (ctl.load_div) begin
         // dividend * 256, top part compared first for overflow
         rem_in   = {1'b0, dividend[31:7]};
         sat_in   = ({1'b0, dividend[31:7]} >= {2'b00, root_ff});
         shift_in = {dividend[6:0], 8'd0, 33'd0};
         quo_in   = '0;
      end else if (ctl.step_div) begin
         shift_in = {shift_ff[46:0], 1'b0};
         if (dv_cat >= {2'b00, root_ff}) begin
            rem_in = dv_cat - {2'b00, root_ff};
            quo_in = {quo_ff[13:0], 1'b1};
         end else begin
            rem_in = dv_cat;
            quo_in = {quo_ff[13:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      root_ff  <= root_in;
      quo_ff   <= quo_in;
      sat_ff   <= sat_in;
   end

   assign root = root_ff;
   assign quo  = quo_ff;
   assign sat  = sat_ff;

endmodule
`default_nettype wire

// ===== sv/qscd_checker.sv =====
`default_nettype none
module qscd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // nothing pending out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // one item in flight: intake closes right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted back to back");

   // a result needs the multi-cycle sequence, never the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result too early");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[23:18] == 6'd0))
      else $error("padding bits set");

endmodule

bind am_quasi_sync_carrier_detector_top qscd_checker u_qscd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== sim/am_quasi_sync_carrier_detector_top_test.sv =====
`default_nettype none
module am_quasi_sync_carrier_detector_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import qscd_pkg::*;

   // ---------------------------------------------------------------------
   // Detector predictor plus expected-video queue
   // ---------------------------------------------------------------------
   class video_scoreboard;
      bit          qsync;
      bit   [31:0] step;
      bit   [23:0] kp;
      bit   [23:0] ki;
      bit   [45:0] flimit;
      bit   [31:0] phase;
      longint      integ;
      logic signed [17:0] video_q[$];
      int          errors;
      int          checked;

      function void reset_state();
         qsync  = 1'b1;
         step   = 32'd0;
         kp     = 24'd683565;
         ki     = 24'd448000;
         flimit = 46'd1759218604442;
         phase  = 32'd0;
         integ  = 0;
      endfunction

      function void write_reg(csr_index_type a, bit [45:0] v);
         case (a)
            CSR_MODE:   qsync  = v[0];
            CSR_STEP:   step   = v[31:0];
            CSR_PGAIN:  kp     = v[23:0];
            CSR_IGAIN:  ki     = v[23:0];
            CSR_FLIMIT: flimit = v;
            default: ;
         endcase
      endfunction

      // integer square root, bit by bit
      function longint root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return longint'(r);
      endfunction

      function longint fshr(longint x, int n);
         return x >>> n;   // arithmetic shift is floor
      endfunction

      // Q1.15 sine, pos in units of a turn / 4096
      function longint sine(int pos);
         int p, quad, rem;
         longint t, t2, poly, s, v;
         p    = pos % 4096;
         quad = p / 1024;
         rem  = p % 1024;
         if (quad & 1) rem = 1024 - rem;
         t    = (longint'(rem) <<< 30) / 1024;
         t2   = (t * t) / 64'sd1073741824;
         poly = -64'sd3864;
         poly = 64'sd172272 + (poly * t2) / 64'sd1073741824;
         poly = -64'sd5026993 + (poly * t2) / 64'sd1073741824;
         poly = 64'sd85569306 + (poly * t2) / 64'sd1073741824;
         poly = -64'sd693598668 + (poly * t2) / 64'sd1073741824;
         poly = 64'sd1686629713 + (poly * t2) / 64'sd1073741824;
         s    = (poly * t) / 64'sd1073741824;
         v    = (s > 0) ? ((s + 16384) >>> 15) : 0;
         if (v > 32767) v = 32767;
         return (quad >= 2) ? -v : v;
      endfunction

      function void note_item(logic signed [15:0] ii, logic signed [15:0] qq);
         longint i, q, m2, video, s, c, yr, yi, e, lim, trim;
         int idx;
         i  = ii;
         q  = qq;
         m2 = i * i + q * q;
         e  = 0;
         if (!qsync) begin
            video = 2 * root(m2);
         end else begin
            idx = phase[31:22];
            s   = sine(4 * idx);
            c   = sine(4 * idx + 1024);
            yr  = i * c - q * s;
            yi  = i * s + q * c;
            video = 2 * fshr(yr + 16384, 15);
            if (m2 != 0) begin
               e = (yi * 256) / root(m2 << 16);
               if (e > 32767) e = 32767;
               if (e < -32768) e = -32768;
            end
            lim   = longint'(flimit);
            integ = integ + fshr(longint'(ki) * e, 15);
            if (integ > lim) integ = lim;
            if (integ < -lim) integ = -lim;
            trim  = longint'(step) + fshr(longint'(kp) * e, 15) + fshr(integ, 16);
            phase = phase - trim[31:0];
         end
         if (video > 131071) video = 131071;
         if (video < -131072) video = -131072;
         video_q.push_back(video[17:0]);
      endfunction

      function void check_video(logic [23:0] d);
         logic signed [17:0] want;
         if (video_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", d);
            return;
         end
         want = video_q.pop_front();
         checked++;
         if (d[17:0] !== want || d[23:18] !== 6'd0) begin
            errors++;
            if (errors <= 10)
               $display("video mismatch: expected %0d got %0d (pad %b)",
                        want, $signed(d[17:0]), d[23:18]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [45:0] csr_wdata = '0;

   video_scoreboard sb;
   int  sent;
   bit  idle_free;   // stretches with no gaps
   int  n_qsync;
   int  n_env;
   int  req_gap = 0; // idle cycles before the next item, drawn after each accept

   always #6 clock = ~clock;

   am_quasi_sync_carrier_detector_top dut (.*);

   // response side: random stall per item, check at accept edge
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_video(rsp_tdata);
         gap = idle_free ? 0 : $urandom_range(0, 18);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // valid stays high across a zero gap, so the next item follows directly
   task automatic send_item(logic [15:0] ii, logic [15:0] qq);
      repeat (req_gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {qq, ii};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(ii, qq);
      if (sb.qsync) n_qsync++; else n_env++;
      sent++;
      req_gap = idle_free ? 0 : $urandom_range(0, 18);
      if (req_gap != 0) req_tvalid <= 1'b0;
   endtask

   // register writes only once every result is back and the block is idle
   task automatic drain();
      int guard;
      guard = 0;
      if (req_gap == 0) req_tvalid <= 1'b0;
      while (sb.video_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type a, logic [45:0] v);
      csr_wen   <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(a, v);
      csr_wen <= 1'b0;
   endtask

   // random item: mix of extremes, small values, zero and full-range noise
   task automatic send_random();
      logic [15:0] ii, qq;
      int k;
      k  = $urandom_range(0, 9);
      ii = 16'($urandom);
      qq = 16'($urandom);
      if (k == 0) begin
         ii = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
         qq = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
      end else if (k < 4) begin
         ii = 16'($signed($urandom_range(0, 4000)) - 2000);
         qq = 16'($signed($urandom_range(0, 4000)) - 2000);
      end else if (k == 4) begin
         ii = 16'd0;
         qq = 16'd0;
      end
      send_item(ii, qq);
   endtask

   initial begin
      logic [15:0] ex[6];
      int ph;
      sb = new();
      sb.reset_state();
      idle_free = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes under default quasi-sync, then envelope, then extreme settings
      ex = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5a82};
      for (int j = 0; j < 4; j++) begin
         send_item(ex[j], ex[(j + 1) % 4]);
      end
      send_item(16'h0000, 16'h0000);            // zero input, no error term
      send_item(16'h8000, 16'h8000);            // full-scale negative input
      send_item(16'h7fff, 16'h7fff);
      drain();
      write_csr(CSR_MODE, 46'd0);
      for (int j = 0; j < 6; j++) send_item(ex[j], ex[5 - j]);
      send_item(16'h8000, 16'h8000);
      drain();
      write_csr(csr_index_type'(3'd6), 46'h3fff_ffff_ffff);  // ignored index
      write_csr(CSR_MODE, 46'd1);
      write_csr(CSR_STEP, 46'hffff_ffff);
      write_csr(CSR_PGAIN, 46'hff_ffff);
      write_csr(CSR_IGAIN, 46'hff_ffff);
      write_csr(CSR_FLIMIT, 46'h3fff_ffff_ffff);
      for (int j = 0; j < 6; j++) send_item(ex[j], ex[(j + 2) % 6]);
      drain();

      // random phases over assorted settings
      for (ph = 0; ph < 10; ph++) begin
         write_csr(CSR_MODE, (ph % 4 == 3) ? 46'd0 : 46'd1);
         write_csr(CSR_STEP, ph == 1 ? 46'd0 : {14'd0, 32'($urandom)});
         write_csr(CSR_PGAIN, ph == 2 ? 46'd0 : {22'd0, 24'($urandom)});
         write_csr(CSR_IGAIN, ph == 2 ? 46'hff_ffff : {22'd0, 24'($urandom)});
         write_csr(CSR_FLIMIT, ph == 4 ? 46'd0 :
                   (ph == 5 ? 46'h3fff_ffff_ffff : {$urandom, 14'($urandom)}));
         idle_free = (ph % 3 == 1);
         repeat (62) send_random();
         drain();
      end

      $display("sent %0d items: %0d quasi-sync, %0d envelope; %0d results checked",
               sent, n_qsync, n_env, sb.checked);
      if (sb.errors == 0 && sb.video_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors, %0d left over", sb.errors, sb.video_q.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest run of ~700 items
   initial begin
      #(12ns * 400000);
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
